// File: hw/rtl/tes_pkg.sv
// Package: shared types and constants for the task/event scheduler table.
`default_nettype none
package tes_pkg;
  localparam int MaxTasks   = 64;
  localparam int MaxEvents  = 128;
  localparam int MaxWaiters = 8;
  localparam int TaskW  = $clog2(MaxTasks);
  localparam int SlotW  = $clog2(MaxEvents);
  localparam int WaitW  = $clog2(MaxWaiters);
  localparam int TCntW  = TaskW + 1;
  localparam int SCntW  = SlotW + 1;
  localparam int WCntW  = WaitW + 1;

  typedef enum logic [3:0] {
    OP_SPAWN = 4'd0, OP_CANCEL = 4'd1, OP_ALLOC = 4'd2, OP_READ = 4'd3,
    OP_FIRE = 4'd4, OP_RDYQ = 4'd5, OP_PICK = 4'd6, OP_OUTCOME = 4'd7,
    OP_TQUERY = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_READY = 3'd0, ST_YIELDED = 3'd1, ST_DONE = 3'd2,
    ST_CANCELLED = 3'd3, ST_WAITING = 3'd4
  } tstate_e;

  typedef enum logic [2:0] {
    RC_OK = 3'd0, RC_BLOCKED = 3'd1, RC_NO_TASK = 3'd2,
    RC_INVALID = 3'd3, RC_FULL = 3'd4, RC_NONE = 3'd5
  } rc_e;

  localparam logic [1:0] OC_YIELD = 2'd0;
  localparam logic [1:0] OC_FINISH = 2'd1;
  localparam logic [1:0] OC_BLOCK = 2'd2;

  typedef enum logic [3:0] {
    FS_IDLE, FS_RD, FS_EXEC, FS_WRD, FS_WCHK, FS_SCAN, FS_SCHK, FS_OUT
  } fsm_e;
endpackage
`default_nettype wire

// File: hw/rtl/task_event_scheduler_table_core.sv
// Top level: task/event scheduler table, memory based, one command at a time.
// Steps: capture, memory read (RD), execute (EXEC), load into the output register (OUT);
// fire adds a waiter-entry read and a task-status check per queued waiter; pick scans entries
// (two passes max). Input is taken only in the idle state, so one command is done at a time.
// A finished result waits in the work registers while the output register still holds a beat.
// Reset clears counters, pick cursor and control; tables are written before use.
`default_nettype none
module task_event_scheduler_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [5:0]  task_index_i,
  input  wire logic [5:0]  reader_task_i,
  input  wire logic        in_task_i,
  input  wire logic [6:0]  event_slot_i,
  input  wire logic [7:0]  segment_total_i,
  input  wire logic [63:0] fire_payload_i,
  input  wire logic [1:0]  segment_outcome_i,
  input  wire logic [63:0] finish_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       result_code_o,
  output logic [6:0]       result_index_o,
  output logic [63:0]      result_data_o,
  output logic             result_flag_o,
  output logic [2:0]       task_state_o
);
  localparam int TW = tes_pkg::TaskW;
  localparam int SW = tes_pkg::SlotW;
  localparam int WW = tes_pkg::WaitW;

  // task memory: status, cursor, length, value
  logic [2:0]  t_st_mem  [tes_pkg::MaxTasks];
  logic [7:0]  t_cur_mem [tes_pkg::MaxTasks];
  logic [7:0]  t_len_mem [tes_pkg::MaxTasks];
  logic [63:0] t_val_mem [tes_pkg::MaxTasks];
  // slot memory
  logic        s_rdy_mem [tes_pkg::MaxEvents];
  logic [63:0] s_pay_mem [tes_pkg::MaxEvents];
  logic [tes_pkg::WCntW-1:0] s_cnt_mem [tes_pkg::MaxEvents];
  logic [TW-1:0] w_mem [tes_pkg::MaxEvents*tes_pkg::MaxWaiters];

  tes_pkg::fsm_e state_q, state_d;
  logic [3:0]  op_q;
  logic [TW-1:0] tix_q, cur_q;
  logic        intask_q;
  logic [SW-1:0] slot_q;
  logic [7:0]  segs_q;
  logic [63:0] pay_q, fval_q;
  logic [1:0]  oc_q;
  logic [tes_pkg::TCntW-1:0] tasks_used_q, tasks_used_d;
  logic [tes_pkg::SCntW-1:0] slots_used_q, slots_used_d;
  logic [tes_pkg::TCntW-1:0] pick_pos_q, pick_pos_d;
  logic        ran_any_q, ran_any_d;
  logic [tes_pkg::TCntW-1:0] scan_q, scan_d;
  logic        second_q, second_d;
  logic [WW:0] wi_q, wi_d;

  // result registers
  logic [2:0]  rc_q, rc_d;
  logic [6:0]  ri_q, ri_d;
  logic [63:0] rd_q, rd_d;
  logic        rf_q, rf_d;
  logic [2:0]  rs_q, rs_d;
  logic        ov_q, ov_d;

  // output register
  logic        out_load;
  logic [2:0]  res_code_q;
  logic [6:0]  res_index_q;
  logic [63:0] res_data_q;
  logic        res_flag_q;
  logic [2:0]  res_state_q;

  // memory read ports (registered)
  logic [TW-1:0] t_ra;
  logic [SW-1:0] s_ra;
  logic [2:0]  t_st_r;
  logic [7:0]  t_cur_r, t_len_r;
  logic [63:0] t_val_r, s_pay_r;
  logic        s_rdy_r;
  logic [tes_pkg::WCntW-1:0] s_cnt_r;
  logic [TW-1:0] w_r;
  logic [SW+WW-1:0] w_ra;

  // write controls
  logic        t_we;
  logic [TW-1:0] t_wa;
  logic [2:0]  t_st_w;
  logic [7:0]  t_cur_w, t_len_w;
  logic [63:0] t_val_w;
  logic        s_we;
  logic [SW-1:0] s_wa;
  logic        s_rdy_w;
  logic [63:0] s_pay_w;
  logic [tes_pkg::WCntW-1:0] s_cnt_w;
  logic        w_we;
  logic [SW+WW-1:0] w_wa;

  logic accept;
  assign in_ready_o = (state_q == tes_pkg::FS_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign result_code_o = res_code_q;
  assign result_index_o = res_index_q;
  assign result_data_o = res_data_q;
  assign result_flag_o = res_flag_q;
  assign task_state_o = res_state_q;

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i; tix_q <= task_index_i; cur_q <= reader_task_i;
      intask_q <= in_task_i; slot_q <= event_slot_i; segs_q <= segment_total_i;
      pay_q <= fire_payload_i; oc_q <= segment_outcome_i; fval_q <= finish_value_i;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_st_mem[t_wa] <= t_st_w; t_cur_mem[t_wa] <= t_cur_w;
      t_len_mem[t_wa] <= t_len_w; t_val_mem[t_wa] <= t_val_w;
    end
    t_st_r <= t_st_mem[t_ra]; t_cur_r <= t_cur_mem[t_ra];
    t_len_r <= t_len_mem[t_ra]; t_val_r <= t_val_mem[t_ra];
  end
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_rdy_mem[s_wa] <= s_rdy_w; s_pay_mem[s_wa] <= s_pay_w; s_cnt_mem[s_wa] <= s_cnt_w;
    end
    s_rdy_r <= s_rdy_mem[s_ra]; s_pay_r <= s_pay_mem[s_ra]; s_cnt_r <= s_cnt_mem[s_ra];
  end
  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= cur_q;
    w_r <= w_mem[w_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tes_pkg::FS_IDLE; tasks_used_q <= '0; slots_used_q <= '0;
      pick_pos_q <= '0; ran_any_q <= 1'b0; ov_q <= 1'b0;
      scan_q <= '0; second_q <= 1'b0; wi_q <= '0;
    end else begin
      state_q <= state_d; tasks_used_q <= tasks_used_d; slots_used_q <= slots_used_d;
      pick_pos_q <= pick_pos_d; ran_any_q <= ran_any_d; ov_q <= ov_d;
      scan_q <= scan_d; second_q <= second_d; wi_q <= wi_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rc_q <= rc_d; ri_q <= ri_d; rd_q <= rd_d; rf_q <= rf_d; rs_q <= rs_d;
  end

  // output beat, held until accepted
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_code_q <= rc_q; res_index_q <= ri_q; res_data_q <= rd_q;
      res_flag_q <= rf_q; res_state_q <= rs_q;
    end
  end

  logic t_ok, s_ok, cur_ok, runnable;
  logic [TW-1:0] addr_task;
  assign t_ok = {1'b0, tix_q} < tasks_used_q;
  assign cur_ok = {1'b0, cur_q} < tasks_used_q;
  assign s_ok = {1'b0, slot_q} < slots_used_q;
  assign runnable = ((t_st_r == tes_pkg::ST_READY) || (t_st_r == tes_pkg::ST_YIELDED))
                    && (t_cur_r < t_len_r);
  assign addr_task = (op_q == tes_pkg::OP_READ) ? cur_q : tix_q;

  // next state and outputs
  always_comb begin
    state_d = state_q; tasks_used_d = tasks_used_q; slots_used_d = slots_used_q;
    pick_pos_d = pick_pos_q; ran_any_d = ran_any_q; scan_d = scan_q;
    second_d = second_q; wi_d = wi_q;
    rc_d = rc_q; ri_d = ri_q; rd_d = rd_q; rf_d = rf_q; rs_d = rs_q;
    ov_d = ov_q;
    out_load = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    t_ra = addr_task; s_ra = slot_q; w_ra = {slot_q, wi_q[WW-1:0]};
    t_we = 1'b0; t_wa = addr_task; t_st_w = t_st_r; t_cur_w = t_cur_r;
    t_len_w = t_len_r; t_val_w = t_val_r;
    s_we = 1'b0; s_wa = slot_q; s_rdy_w = s_rdy_r; s_pay_w = s_pay_r; s_cnt_w = s_cnt_r;
    w_we = 1'b0; w_wa = {slot_q, s_cnt_r[WW-1:0]};
    case (state_q)
      tes_pkg::FS_IDLE: if (accept) state_d = tes_pkg::FS_RD;
      tes_pkg::FS_RD: state_d = tes_pkg::FS_EXEC;
      tes_pkg::FS_EXEC: begin
        rc_d = tes_pkg::RC_OK; ri_d = '0; rd_d = '0; rf_d = 1'b0; rs_d = '0;
        state_d = tes_pkg::FS_OUT;
        case (op_q)
          tes_pkg::OP_SPAWN: begin
            if (tasks_used_q >= tes_pkg::TCntW'(tes_pkg::MaxTasks)) rc_d = tes_pkg::RC_FULL;
            else begin
              t_we = 1'b1; t_wa = tasks_used_q[TW-1:0]; t_st_w = tes_pkg::ST_READY;
              t_cur_w = '0; t_len_w = segs_q; t_val_w = '0;
              ri_d = 7'(tasks_used_q); tasks_used_d = tasks_used_q + 1'b1;
            end
          end
          tes_pkg::OP_CANCEL: begin
            if (!t_ok) rc_d = tes_pkg::RC_INVALID;
            else begin
              ri_d = 7'(tix_q);
              if (t_st_r != tes_pkg::ST_DONE && t_st_r != tes_pkg::ST_CANCELLED) begin
                t_we = 1'b1; t_st_w = tes_pkg::ST_CANCELLED; rs_d = tes_pkg::ST_CANCELLED;
              end else begin
                rs_d = t_st_r; rf_d = (t_st_r == tes_pkg::ST_DONE);
              end
            end
          end
          tes_pkg::OP_ALLOC: begin
            if (slots_used_q >= tes_pkg::SCntW'(tes_pkg::MaxEvents)) rc_d = tes_pkg::RC_FULL;
            else begin
              s_we = 1'b1; s_wa = slots_used_q[SW-1:0]; s_rdy_w = 1'b0; s_pay_w = '0;
              s_cnt_w = '0; ri_d = 7'(slots_used_q); slots_used_d = slots_used_q + 1'b1;
            end
          end
          tes_pkg::OP_READ: begin
            if (!s_ok) rc_d = tes_pkg::RC_INVALID;
            else if (s_rdy_r) begin
              ri_d = 7'(slot_q); rd_d = s_pay_r; rf_d = 1'b1;
            end else if (!intask_q) begin
              // slot id is still reported
              rc_d = tes_pkg::RC_NO_TASK; ri_d = 7'(slot_q);
            end else begin
              ri_d = 7'(slot_q); rc_d = tes_pkg::RC_BLOCKED;
              if (s_cnt_r < tes_pkg::WCntW'(tes_pkg::MaxWaiters)) begin
                w_we = 1'b1; s_we = 1'b1; s_cnt_w = s_cnt_r + 1'b1;
              end
              if (cur_ok) begin
                if (t_st_r == tes_pkg::ST_READY || t_st_r == tes_pkg::ST_YIELDED) begin
                  t_we = 1'b1; t_st_w = tes_pkg::ST_WAITING; rs_d = tes_pkg::ST_WAITING;
                end else rs_d = t_st_r;
              end
            end
          end
          tes_pkg::OP_FIRE: begin
            if (!s_ok) rc_d = tes_pkg::RC_INVALID;
            else begin
              ri_d = 7'(slot_q); rf_d = 1'b1;
              s_we = 1'b1; s_rdy_w = 1'b1; s_pay_w = pay_q; s_cnt_w = '0;
              wi_d = '0;
              // walk waiters using the count read before the clear
              if (s_cnt_r != '0) begin
                scan_d = tes_pkg::TCntW'(s_cnt_r);
                state_d = tes_pkg::FS_WRD;
              end
            end
          end
          tes_pkg::OP_RDYQ: begin
            if (!s_ok) rc_d = tes_pkg::RC_INVALID;
            else begin ri_d = 7'(slot_q); rf_d = s_rdy_r; end
          end
          tes_pkg::OP_PICK: begin
            scan_d = pick_pos_q; second_d = 1'b0; state_d = tes_pkg::FS_SCAN;
          end
          tes_pkg::OP_OUTCOME: begin
            if (!t_ok) rc_d = tes_pkg::RC_INVALID;
            else begin
              ri_d = 7'(tix_q); rs_d = t_st_r; rd_d = t_val_r;
              rf_d = (t_st_r == tes_pkg::ST_DONE);
              case (oc_q)
                tes_pkg::OC_FINISH: begin
                  t_we = 1'b1; t_st_w = tes_pkg::ST_DONE; t_val_w = fval_q;
                  rs_d = tes_pkg::ST_DONE; rd_d = fval_q; rf_d = 1'b1;
                end
                tes_pkg::OC_BLOCK: begin
                  t_we = 1'b1; t_st_w = tes_pkg::ST_WAITING;
                  rs_d = tes_pkg::ST_WAITING; rf_d = 1'b0;
                end
                tes_pkg::OC_YIELD: begin
                  t_we = 1'b1; t_st_w = tes_pkg::ST_YIELDED;
                  if (t_cur_r != 8'hFF) t_cur_w = t_cur_r + 1'b1;
                  rs_d = tes_pkg::ST_YIELDED; rf_d = 1'b0;
                end
                default: ;
              endcase
            end
          end
          tes_pkg::OP_TQUERY: begin
            if (!t_ok) rc_d = tes_pkg::RC_INVALID;
            else begin
              ri_d = 7'(tix_q); rs_d = t_st_r; rd_d = t_val_r;
              rf_d = (t_st_r == tes_pkg::ST_DONE);
            end
          end
          default: rc_d = tes_pkg::RC_INVALID;
        endcase
      end
      // fire: read waiter entry, then task status
      tes_pkg::FS_WRD: begin
        state_d = tes_pkg::FS_WCHK;
      end
      tes_pkg::FS_WCHK: begin
        t_ra = w_r;
        state_d = tes_pkg::FS_SCHK;
        second_d = 1'b1;
      end
      tes_pkg::FS_SCHK: begin
        if (op_q == tes_pkg::OP_FIRE) begin
          t_wa = w_r;
          if ({1'b0, w_r} < tasks_used_q && t_st_r == tes_pkg::ST_WAITING) begin
            t_we = 1'b1; t_st_w = tes_pkg::ST_READY;
          end
          wi_d = wi_q + 1'b1;
          if (tes_pkg::TCntW'(wi_q + 1'b1) >= scan_q) state_d = tes_pkg::FS_OUT;
          else state_d = tes_pkg::FS_WRD;
        end else begin
          // pick: t_st_r holds entry scan_q
          if (runnable) begin
            pick_pos_d = scan_q + 1'b1; ran_any_d = 1'b1;
            ri_d = 7'(scan_q); rs_d = t_st_r; state_d = tes_pkg::FS_OUT;
          end else begin
            scan_d = scan_q + 1'b1; state_d = tes_pkg::FS_SCAN;
          end
        end
      end
      tes_pkg::FS_SCAN: begin
        t_ra = scan_q[TW-1:0];
        if (scan_q >= tasks_used_q) begin
          if (!second_q && ran_any_q) begin
            ran_any_d = 1'b0; second_d = 1'b1; scan_d = '0;
          end else begin
            pick_pos_d = '0; ran_any_d = 1'b0; rc_d = tes_pkg::RC_NONE;
            state_d = tes_pkg::FS_OUT;
          end
        end else state_d = tes_pkg::FS_SCHK;
      end
      tes_pkg::FS_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; out_load = 1'b1; state_d = tes_pkg::FS_IDLE;
        end
      end
      default: state_d = tes_pkg::FS_IDLE;
    endcase
  end

  // checks
  a_cnt_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tasks_used_q <= tes_pkg::TCntW'(tes_pkg::MaxTasks)) else $error("task count overflow");
  a_cnt_s: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q <= tes_pkg::SCntW'(tes_pkg::MaxEvents)) else $error("slot count overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(result_data_o))
    else $error("result dropped");
endmodule
`default_nettype wire
